// File: hdl/rbss_pkg.sv
package rbss_pkg;

  // Default sizing of the slot table and the admission queue
  localparam int unsigned SLOT_COUNT_DEF  = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 1024;

  // Field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 64;
  localparam int unsigned TOK_W  = 20;
  localparam int unsigned SEQ_W  = 21;
  localparam int unsigned LIM_W  = 11;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned ACT_W  = 7;
  localparam int unsigned PEND_W = 11;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 21;

  // Register reset values
  localparam logic [SEQ_W-1:0] MAX_SEQ_LEN_RST   = 21'd131072;
  localparam logic [LIM_W-1:0] PENDING_LIMIT_RST = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_SCHEDULE = 2'd1,
    FUNC_COMPLETE = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_LONG     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SEQ_LEN   = 1'b0,
    CFG_PENDING_LIMIT = 1'b1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic submit;    // run the admission checks, push, emit
    logic place;     // fill the lowest free slot from the queue head, emit
    logic empty;     // emit an empty-batch result
    logic complete;  // free the matched slot, emit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sched_go;    // queue not empty and a slot is free
    logic              place_last;  // this placement ends the batch
  } sts_t;

endpackage

// File: hdl/request_batch_slot_scheduler.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: req_id, prompt_tokens,
//                                                     output_budget; tuser: func
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: out_id, start_position,
//                                                     slot_index, active_count,
//                                                     pending_count; tuser: status;
//                                                     tlast: last
// cfg       in         cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
// Submit is answered from the decode state, complete from the free state; a
// schedule passes the schedule and place states once per placement (one queue
// memory read and one slot write per placement) or answers empty.
// One item is in work at a time; the next is taken as soon as the controller is
// back in idle, while the last result may still sit in the output register.
// A stalled m_axis holds the controller before each result it would load.
// Reset clears counters, pointers, busy bits and config; queue and slot ids
// need no clearing pass since they are read only after being written.
module request_batch_slot_scheduler #(
  parameter int unsigned SLOT_COUNT  = rbss_pkg::SLOT_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = rbss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // req_id [63:0], prompt_tokens [83:64], output_budget [103:84]
  input  logic [rbss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  logic [rbss_pkg::FUNC_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_id [63:0], start_position [83:64], slot_index [89:84],
  // active_count [96:90], pending_count [107:97], zero pad [111:108]
  output logic [rbss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [rbss_pkg::STAT_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast
);
  import rbss_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [TOK_W-1:0]  start_position;
  logic [SLOT_W-1:0] slot_index;
  logic [ACT_W-1:0]  active_count;
  logic [PEND_W-1:0] pending_count;

  rbss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbss_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (s_axis_tuser),
    .req_id_i         (s_axis_tdata[63:0]),
    .prompt_tokens_i  (s_axis_tdata[83:64]),
    .output_budget_i  (s_axis_tdata[103:84]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status),
    .out_id_o         (out_id),
    .start_position_o (start_position),
    .slot_index_o     (slot_index),
    .active_count_o   (active_count),
    .pending_count_o  (pending_count),
    .last_o           (m_axis_tlast)
  );

  // Pack the result, lowest field first
  assign m_axis_tdata = {4'b0000, pending_count, active_count, slot_index,
                         start_position, out_id};
  assign m_axis_tuser = status;

  // One item at a time: a transfer closes the input until the item is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Active count never exceeds the slot table
  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (active_count <= ACT_W'(SLOT_COUNT)))
    else $error("active count above slot count");

  // Empty batch is a single, id-free result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == STAT_EMPTY)) |-> (m_axis_tlast && (out_id == '0)))
    else $error("empty batch result malformed");

  // Refusals carry no id and end their item
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((status == STAT_FULL) || (status == STAT_LONG) ||
                       (status == STAT_NOTFOUND)))
    |-> ((out_id == '0) && m_axis_tlast && (slot_index == '0)))
    else $error("refusal result carries an id or slot");

endmodule

// File: hdl/rbss_ctrl.sv
module rbss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  rbss_pkg::sts_t sts_i,
  output rbss_pkg::cmd_t cmd_o
);
  import rbss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCHED  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_FREE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   out_load;

  // Result register is free when empty or drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.func)
          FUNC_SUBMIT: begin
            if (out_free) begin
              cmd_o.submit = 1'b1;
              state_d      = S_IDLE;
            end
          end
          FUNC_SCHEDULE: state_d = S_SCHED;
          FUNC_COMPLETE: state_d = S_FREE;
          default:       state_d = S_IDLE;  // drop unknown operations
        endcase
      end
      S_SCHED: begin
        if (sts_i.sched_go) begin
          state_d = S_PLACE;
        end else if (out_free) begin
          cmd_o.empty = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PLACE: begin
        if (out_free) begin
          cmd_o.place = 1'b1;
          state_d     = sts_i.place_last ? S_IDLE : S_SCHED;
        end
      end
      S_FREE: begin
        if (out_free) begin
          cmd_o.complete = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = cmd_o.submit || cmd_o.place || cmd_o.empty || cmd_o.complete;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/rbss_dp.sv
module rbss_dp #(
  parameter int unsigned SLOT_COUNT  = rbss_pkg::SLOT_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = rbss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rbss_pkg::FUNC_W-1:0]   func_i,
  input  logic [rbss_pkg::ID_W-1:0]     req_id_i,
  input  logic [rbss_pkg::TOK_W-1:0]    prompt_tokens_i,
  input  logic [rbss_pkg::TOK_W-1:0]    output_budget_i,
  input  rbss_pkg::cmd_t                cmd_i,
  output rbss_pkg::sts_t                sts_o,
  output logic [rbss_pkg::STAT_W-1:0]   status_o,
  output logic [rbss_pkg::ID_W-1:0]     out_id_o,
  output logic [rbss_pkg::TOK_W-1:0]    start_position_o,
  output logic [rbss_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [rbss_pkg::ACT_W-1:0]    active_count_o,
  output logic [rbss_pkg::PEND_W-1:0]   pending_count_o,
  output logic                          last_o
);
  import rbss_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW  = QAW + 2;
  localparam int unsigned CW  = (FW > LIM_W) ? FW : LIM_W;
  localparam int unsigned SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned BW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned EW  = ID_W + TOK_W;

  // Captured item
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [TOK_W-1:0]  prompt_q;
  logic [TOK_W-1:0]  budget_q;

  // Configuration
  logic [SEQ_W-1:0] max_seq_len_q;
  logic [LIM_W-1:0] pending_limit_q;

  // Admission queue
  logic [EW-1:0]  queue_mem [QUEUE_DEPTH];
  logic [EW-1:0]  rd_q;
  logic [QAW-1:0] head_q, head_d;
  logic [FW-1:0]  fill_q, fill_d;

  // Slot table
  logic [ID_W-1:0]       slot_id_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [SLOT_COUNT-1:0] match_q, match_c;
  logic [BW-1:0]         busy_total_q, busy_total_d;

  // Output register
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [TOK_W-1:0]  start_q, start_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ACT_W-1:0]  active_q;
  logic [PEND_W-1:0] pending_q;
  logic              last_q, last_d;
  logic              out_load;

  logic [CW-1:0]         lim_ext, depth_ext, limit;
  logic                  full;
  logic [SEQ_W-1:0]      tok_sum;
  logic                  too_long;
  logic                  push;
  logic [TW-1:0]         tail_sum, tail_wrap;
  logic [QAW-1:0]        tail;
  logic [SLOT_COUNT-1:0] free_vec, free_onehot;
  logic [SIW-1:0]        free_idx, match_idx;
  logic                  found;
  logic                  place_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      id_q     <= req_id_i;
      prompt_q <= prompt_tokens_i;
      budget_q <= output_budget_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seq_len_q   <= MAX_SEQ_LEN_RST;
      pending_limit_q <= PENDING_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_SEQ_LEN:   max_seq_len_q   <= cfg_data_i;
        CFG_PENDING_LIMIT: pending_limit_q <= cfg_data_i[LIM_W-1:0];
        default:           ;
      endcase
    end
  end

  // Submit checks: pending limit clamped to the queue depth, then token length
  always_comb begin
    lim_ext   = CW'(pending_limit_q);
    depth_ext = CW'(QUEUE_DEPTH);
    limit     = (lim_ext > depth_ext) ? depth_ext : lim_ext;
  end
  assign full     = CW'(fill_q) >= limit;
  assign tok_sum  = {1'b0, prompt_q} + {1'b0, budget_q};
  assign too_long = tok_sum > max_seq_len_q;
  assign push     = cmd_i.submit && !full && !too_long;

  // Tail slot: head + fill wrapped once around the queue
  assign tail_sum  = TW'(head_q) + TW'(fill_q);
  assign tail_wrap = (tail_sum >= TW'(QUEUE_DEPTH)) ? tail_sum - TW'(QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[QAW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail] <= {prompt_q, id_q};
    end
    rd_q <= queue_mem[head_q];
  end

  // Lowest free slot
  assign free_vec = ~busy_q;
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = SIW'(i);
      end
    end
  end
  assign free_onehot = SLOT_COUNT'(1) << free_idx;

  // A placement ends the batch when it takes the last queued request or the
  // last free slot
  assign place_last = (fill_q == FW'(1)) || ((free_vec & ~free_onehot) == '0);

  // Id compare against every busy slot, registered before encoding
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_c[i] = busy_q[i] && (slot_id_q[i] == id_q);
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_c;
  end

  always_comb begin
    match_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        match_idx = SIW'(i);
      end
    end
  end
  assign found = |match_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      slot_id_q[free_idx] <= rd_q[ID_W-1:0];
    end
  end

  // Counter and pointer updates
  always_comb begin
    head_d       = head_q;
    fill_d       = fill_q;
    busy_d       = busy_q;
    busy_total_d = busy_total_q;
    if (push) begin
      fill_d = fill_q + FW'(1);
    end
    if (cmd_i.place) begin
      head_d       = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
      fill_d       = fill_q - FW'(1);
      busy_d       = busy_q | free_onehot;
      busy_total_d = busy_total_q + BW'(1);
    end
    if (cmd_i.complete && found) begin
      busy_d[match_idx] = 1'b0;
      busy_total_d      = busy_total_q - BW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      fill_q       <= '0;
      busy_q       <= '0;
      busy_total_q <= '0;
    end else begin
      head_q       <= head_d;
      fill_q       <= fill_d;
      busy_q       <= busy_d;
      busy_total_q <= busy_total_d;
    end
  end

  // Result fields
  always_comb begin
    status_d = STAT_OK;
    out_id_d = '0;
    start_d  = '0;
    slot_d   = '0;
    last_d   = 1'b1;
    if (cmd_i.submit) begin
      status_d = full ? STAT_FULL : (too_long ? STAT_LONG : STAT_OK);
      out_id_d = push ? id_q : '0;
    end
    if (cmd_i.place) begin
      out_id_d = rd_q[ID_W-1:0];
      start_d  = rd_q[EW-1:ID_W];
      slot_d   = SLOT_W'(free_idx);
      last_d   = place_last;
    end
    if (cmd_i.empty) begin
      status_d = STAT_EMPTY;
    end
    if (cmd_i.complete) begin
      status_d = found ? STAT_OK : STAT_NOTFOUND;
      out_id_d = found ? id_q : '0;
      slot_d   = found ? SLOT_W'(match_idx) : '0;
    end
  end

  assign out_load = cmd_i.submit || cmd_i.place || cmd_i.empty || cmd_i.complete;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      out_id_q  <= out_id_d;
      start_q   <= start_d;
      slot_q    <= slot_d;
      active_q  <= ACT_W'(busy_total_d);
      pending_q <= PEND_W'(fill_d);
      last_q    <= last_d;
    end
  end

  assign sts_o.func       = func_q;
  assign sts_o.sched_go   = (fill_q != '0) && (|free_vec);
  assign sts_o.place_last = place_last;

  assign status_o         = status_q;
  assign out_id_o         = out_id_q;
  assign start_position_o = start_q;
  assign slot_index_o     = slot_q;
  assign active_count_o   = active_q;
  assign pending_count_o  = pending_q;
  assign last_o           = last_q;

endmodule

// File: dv/tb_request_batch_slot_scheduler.sv
`timescale 1ns / 1ps

module tb_request_batch_slot_scheduler;
  import rbss_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int TOK_MAX     = (1 << TOK_W) - 1;
  localparam int SUM_MAX     = 2 * TOK_MAX;
  localparam int SEQ_MAX     = (1 << SEQ_W) - 1;
  // Room for a schedule that fills every slot, with margin.
  localparam int SETTLE_CYC  = 2 * SLOTS + 12;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_N      = 24;
  localparam int MAX_REPORTS = 40;
  // The one func code the block ignores without a result.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One request as the sender offers it.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [TOK_W-1:0]  prompt;
    logic [TOK_W-1:0]  budget;
    bit                hold;  // offer only once every outstanding result is back
  } sched_req_t;

  // One result as the block should return it.
  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [TOK_W-1:0]  start_pos;
    logic [SLOT_W-1:0] slot;
    logic [ACT_W-1:0]  active;
    logic [PEND_W-1:0] pending;
    logic              last;
  } sched_rsp_t;

  // Block ports; every input holds a known value from time zero.
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  // Scheduler shadow: limits, admission queue and slot table.
  logic [SEQ_W-1:0] lim_seq  = MAX_SEQ_LEN_RST;
  logic [LIM_W-1:0] lim_pend = PENDING_LIMIT_RST;
  logic [ID_W-1:0]  adm_id[$];
  logic [TOK_W-1:0] adm_len[$];
  logic [ID_W-1:0]  slot_id  [SLOTS];
  logic [TOK_W-1:0] slot_len [SLOTS];
  bit               slot_busy[SLOTS];
  int               busy_n = 0;

  sched_req_t request_q[$];  // requests waiting to be offered
  sched_rsp_t outcome_q[$];  // results still owed by the block
  sched_req_t cur_req;
  int         send_gap  = 0;
  int         sink_gap  = 0;
  int         err_count = 0;
  bit         src_calm  = 1'b0;  // no idling on the sender side
  bit         snk_calm  = 1'b0;  // no stalls on the receiver side
  logic [ID_W-1:0] id_pool[POOL_N];

  request_batch_slot_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Build a result carrying the counts as they stand right now.
  function automatic sched_rsp_t make_rsp(status_e st, logic [ID_W-1:0] id,
                                          logic [TOK_W-1:0] pos, int slot, logic fin);
    sched_rsp_t r;
    r.status    = st;
    r.id        = id;
    r.start_pos = pos;
    r.slot      = SLOT_W'(slot);
    r.active    = ACT_W'(busy_n);
    r.pending   = PEND_W'(adm_id.size());
    r.last      = fin;
    return r;
  endfunction

  // Append one result to the list the block still owes.
  function automatic void owe(sched_rsp_t r);
    outcome_q.insert(outcome_q.size(), r);
  endfunction

  // Advance the shadow by one accepted request and queue what it must return.
  function automatic void predict_outcomes(sched_req_t req);
    int               cap;
    int               placed;
    int               hit;
    sched_rsp_t       held;
    logic [SEQ_W-1:0] total;
    placed = 0;
    hit    = -1;
    case (req.func)
      FUNC_SUBMIT: begin
        // Occupancy check comes first; a limit above the depth means the depth.
        cap   = (lim_pend > DEPTH) ? DEPTH : int'(lim_pend);
        total = SEQ_W'(req.prompt) + SEQ_W'(req.budget);
        if (adm_id.size() >= cap) begin
          owe(make_rsp(STAT_FULL, '0, '0, 0, 1'b1));
        end else if (total > lim_seq) begin
          owe(make_rsp(STAT_LONG, '0, '0, 0, 1'b1));
        end else begin
          adm_id.insert(adm_id.size(), req.id);
          adm_len.insert(adm_len.size(), req.prompt);
          owe(make_rsp(STAT_OK, req.id, '0, 0, 1'b1));
        end
      end
      FUNC_SCHEDULE: begin
        // Walk slots upward, fill each free one from the queue head. Hold back
        // each result until the next placement shows whether it ends the batch.
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_busy[s] && adm_id.size() != 0) begin
            if (placed != 0) owe(held);
            slot_busy[s] = 1'b1;
            slot_id[s]   = adm_id.pop_front();
            slot_len[s]  = adm_len.pop_front();
            busy_n++;
            held = make_rsp(STAT_OK, slot_id[s], slot_len[s], s, 1'b0);
            placed++;
          end
        end
        if (placed == 0) begin
          owe(make_rsp(STAT_EMPTY, '0, '0, 0, 1'b1));
        end else begin
          held.last = 1'b1;
          owe(held);
        end
      end
      FUNC_COMPLETE: begin
        // Lowest busy slot with a matching id wins.
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (slot_busy[s] && slot_id[s] == req.id) hit = s;
        end
        if (hit < 0) begin
          owe(make_rsp(STAT_NOTFOUND, '0, '0, 0, 1'b1));
        end else begin
          slot_busy[hit] = 1'b0;
          busy_n--;
          owe(make_rsp(STAT_OK, req.id, '0, hit, 1'b1));
        end
      end
      default: ;  // unused code: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------

  function automatic int draw_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Results still in flight. Count a transfer on this edge as in flight too, so
  // the answer does not hinge on whether the monitor has run yet.
  function automatic bit results_busy();
    return outcome_q.size() != 0 || (m_axis_tvalid && m_axis_tready);
  endfunction

  // Sender: predict on each transfer, idle a random number of cycles, then
  // offer the next request. Hold tvalid and data while the block stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcomes(cur_req);
        send_gap = draw_gap(src_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0 && !(request_q[0].hold && results_busy())) begin
          cur_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.budget, cur_req.prompt, cur_req.id};
          s_axis_tuser  <= cur_req.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h", $time, what, want, got);
  endtask

  // Compare one transferred result against the oldest owed one.
  task automatic check_result();
    sched_rsp_t want;
    sched_rsp_t got;
    got.status    = status_e'(m_axis_tuser);
    got.id        = m_axis_tdata[63:0];
    got.start_pos = m_axis_tdata[83:64];
    got.slot      = m_axis_tdata[89:84];
    got.active    = m_axis_tdata[96:90];
    got.pending   = m_axis_tdata[107:97];
    got.last      = m_axis_tlast;
    if (outcome_q.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: result with nothing outstanding: status %0d id 'h%0h",
                 $time, got.status, got.id);
      return;
    end
    want = outcome_q.pop_front();
    if (got.status !== want.status)       note_mismatch("status", want.status, got.status);
    if (got.id !== want.id)               note_mismatch("out_id", want.id, got.id);
    if (got.start_pos !== want.start_pos) note_mismatch("start_position", want.start_pos,
                                                        got.start_pos);
    if (got.slot !== want.slot)           note_mismatch("slot_index", want.slot, got.slot);
    if (got.active !== want.active)       note_mismatch("active_count", want.active, got.active);
    if (got.pending !== want.pending)     note_mismatch("pending_count", want.pending,
                                                        got.pending);
    if (got.last !== want.last)           note_mismatch("tlast", want.last, got.last);
    if (m_axis_tdata[111:108] !== '0)     note_mismatch("tdata pad", '0, m_axis_tdata[111:108]);
  endtask

  // Receiver: check each transfer, then stall a random number of cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        sink_gap = draw_gap(snk_calm);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run once nothing has moved on either stream for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** request_batch_slot_scheduler: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_req(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                    int prompt, int budget, bit hold = 1'b0);
    sched_req_t r;
    r.func   = f;
    r.id     = id;
    r.prompt = TOK_W'(prompt);
    r.budget = TOK_W'(budget);
    r.hold   = hold;
    request_q.insert(request_q.size(), r);
  endfunction

  // Mostly ids from a small pool so that completes hit and duplicates occur.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_N - 1)];
    return {$urandom, $urandom};
  endfunction

  // Split a token sum into a prompt and a budget that each fit their field.
  function automatic void split_tokens(int target, output int p, output int b);
    int lo;
    int hi;
    if (target > SUM_MAX) target = SUM_MAX;
    lo = (target > TOK_MAX) ? target - TOK_MAX : 0;
    hi = (target < TOK_MAX) ? target : TOK_MAX;
    p  = $urandom_range(hi, lo);
    b  = target - p;
  endfunction

  // Aim the sum at, just past, or under the current length limit, or draw both at random.
  function automatic void queue_submit(logic [ID_W-1:0] id, bit hold);
    int p;
    int b;
    int lim;
    int sel;
    lim = int'(lim_seq);
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      p = $urandom_range(0, TOK_MAX);
      b = $urandom_range(0, TOK_MAX);
    end else if (sel < 7) begin
      split_tokens(lim, p, b);
    end else if (sel < 10) begin
      split_tokens(lim + 1, p, b);
    end else begin
      split_tokens($urandom_range(0, lim), p, b);
    end
    queue_req(FUNC_SUBMIT, id, p, b, hold);
  endfunction

  // Random mix of operations; ignored codes do not count toward n.
  task automatic random_phase(int n);
    int done;
    int pick;
    bit hold;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      hold = (done == n / 2) || ($urandom_range(0, 39) == 0);
      if (pick < 45) begin
        queue_submit(pick_id(), hold);
      end else if (pick < 65) begin
        queue_req(FUNC_SCHEDULE, {$urandom, $urandom}, $urandom_range(0, TOK_MAX),
                  $urandom_range(0, TOK_MAX), hold);
      end else if (pick < 94) begin
        queue_req(FUNC_COMPLETE, pick_id(), $urandom_range(0, TOK_MAX),
                  $urandom_range(0, TOK_MAX), hold);
      end else begin
        queue_req(FUNC_UNUSED, {$urandom, $urandom}, $urandom_range(0, TOK_MAX),
                  $urandom_range(0, TOK_MAX), hold);
        continue;
      end
      done++;
    end
  endtask

  // Wait until every request is sent and every result is back, then give an
  // ignored request time to leave the block. Sample on the falling edge so the
  // view of the queues is settled.
  task automatic drain_and_settle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write both limit registers while the block is idle. Junk sits above the
  // pending limit's 11 bits; the block must drop it.
  task automatic set_limits(int seq_len, int pend);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_SEQ_LEN;
    cfg_data_i <= CFG_DATA_W'(seq_len);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PENDING_LIMIT;
    cfg_data_i <= {(CFG_DATA_W - LIM_W)'($urandom), LIM_W'(pend)};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim_seq  = SEQ_W'(seq_len);
    lim_pend = LIM_W'(pend);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int seq_tab[6]  = '{1, 1048576, 5000, SEQ_MAX, 0, 131072};
    int pend_tab[6] = '{1, 8, 16, 2047, 4, 1024};
    for (int i = 0; i < POOL_N; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default limits: empty batch, unknown id, ignored code, length boundary,
    // duplicate ids freed lowest slot first.
    set_limits(MAX_SEQ_LEN_RST, PENDING_LIMIT_RST);
    queue_req(FUNC_SCHEDULE, '0, 0, 0);
    queue_req(FUNC_COMPLETE, id_pool[5], 0, 0);
    queue_req(FUNC_UNUSED, '1, TOK_MAX, TOK_MAX);
    queue_req(FUNC_SUBMIT, '1, TOK_MAX, TOK_MAX);
    queue_req(FUNC_SUBMIT, '0, 0, 0);
    queue_req(FUNC_SUBMIT, id_pool[2], 100000, 31072);
    queue_req(FUNC_SUBMIT, id_pool[3], 100000, 31073);
    queue_req(FUNC_SUBMIT, id_pool[2], 5, 7);
    queue_req(FUNC_SCHEDULE, '1, TOK_MAX, TOK_MAX);
    queue_req(FUNC_COMPLETE, id_pool[2], TOK_MAX, TOK_MAX);
    queue_req(FUNC_COMPLETE, id_pool[2], 0, 0);
    queue_req(FUNC_COMPLETE, id_pool[2], 0, 0);
    queue_req(FUNC_COMPLETE, '0, 0, 0);
    queue_req(FUNC_SCHEDULE, '0, 0, 0);
    drain_and_settle();

    // Zero pending limit: refused as full even though the length is fine.
    set_limits(0, 0);
    queue_req(FUNC_SUBMIT, id_pool[4], 0, 0);
    drain_and_settle();

    // Zero length limit: only empty requests get in; then hit a limit of two.
    set_limits(0, 2);
    queue_req(FUNC_SUBMIT, id_pool[4], 0, 0);
    queue_req(FUNC_SUBMIT, id_pool[5], 0, 1);
    queue_req(FUNC_SUBMIT, id_pool[6], 1, 0);
    queue_req(FUNC_SUBMIT, id_pool[7], 0, 0);
    queue_req(FUNC_SUBMIT, id_pool[8], 0, 0);
    queue_req(FUNC_SCHEDULE, '0, 0, 0);
    drain_and_settle();

    // Widest length limit takes the largest sum; pending limit past the depth.
    set_limits(SEQ_MAX, 2047);
    queue_req(FUNC_SUBMIT, '1, TOK_MAX, TOK_MAX);
    queue_req(FUNC_SCHEDULE, '0, 0, 0);
    drain_and_settle();

    // Random traffic across a range of limits; one phase with no idling at all
    // and one with a free-running receiver only.
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(seq_tab[ph], pend_tab[ph]);
      src_calm = (ph == 2);
      snk_calm = (ph == 2 || ph == 4);
      random_phase(30);
      drain_and_settle();
    end

    // Free one slot held by each pool id, if any, then queue a few more requests and
    // place them into the freed slots.
    set_limits(SEQ_MAX, 2047);
    src_calm = 1'b0;
    snk_calm = 1'b0;
    for (int i = 0; i < POOL_N; i++) queue_req(FUNC_COMPLETE, id_pool[i], 0, 0);
    for (int i = 0; i < 12; i++) queue_submit(pick_id(), 1'b0);
    queue_req(FUNC_SCHEDULE, '0, 0, 0);
    drain_and_settle();

    if (err_count == 0)
      $display("** request_batch_slot_scheduler: PASSED **");
    else
      $display("** request_batch_slot_scheduler: FAILED **");
    $finish;
  end

endmodule
